// ----- rtl/gsns_pkg.sv -----
// Shared types, constants and the snap comparison for the guide store.
`default_nettype none

package gsns_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int POS_W         = 32;
    localparam int REG_W         = 31;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int IN_W          = ((OP_W + 2 * POS_W + 7) / 8) * 8;

    localparam logic [REG_W-1:0] PAGE_EXTENT_RST = 31'd55181312;
    localparam logic [REG_W-1:0] MARGIN_NEAR_RST = 31'd2621440;
    localparam logic [REG_W-1:0] MARGIN_FAR_RST  = 31'd2621440;

    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_EXTENT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MARGIN_NEAR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MARGIN_FAR  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_STD  = 3'd0,
        OP_DEL_STD  = 3'd1,
        OP_MOVE_STD = 3'd2,
        OP_CLR_STD  = 3'd3,
        OP_ADD_AUTO = 3'd4,
        OP_CLR_AUTO = 3'd5,
        OP_BEFORE   = 3'd6,
        OP_AFTER    = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FOLD_AUTO,
        S_FOLD_NEAR,
        S_FOLD_FAR,
        S_DONE
    } state_t;

    // True when cand should replace best for a query at y.
    function automatic logic snap_take(input logic after,
                                       input logic signed [POS_W-1:0] cand,
                                       input logic signed [POS_W-1:0] y,
                                       input logic signed [POS_W-1:0] best);
        logic res;
        if (after)
        begin
            res = (cand > y) && (cand < best);
        end
        else
        begin
            res = (cand < y) && (cand > best);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/guide_store_nearest_snap.sv -----
// Top level of the guide store: the chain of cells, the sequencer and the stream ports.
//
// The block keeps a standard and an auto list of Q16.16 guide positions and
// answers nearest-before and nearest-after snap queries.
// Input words arrive on s_tvalid/s_tready/s_tdata, one operation per word;
// each produces exactly one result word on m_tvalid/m_tready/m_tdata.
// Configuration registers (page extent, two margins) go in via cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce this.
// Every word rotates the whole chain of GUIDE_DEPTH cells once, one cell per
// cycle, so that each entry passes the comparator at the head of the chain.
// A word is accepted in the idle state, then the sequencer runs the scan, the fold
// states for the auto list, the near margin and the far line, and the completion
// state that registers the result; no new word is taken until it is back in idle.
// The result sits in an output register, so the next word is accepted while
// it waits; if the receiver still holds off when the next result is ready,
// the sequencer waits in its completion cycle.
// Reset empties both lists and restores the configuration defaults; the
// chain contents are not cleared and need no clearing pass.
`default_nettype none

module guide_store_nearest_snap #(
    parameter int GUIDE_DEPTH = gsns_pkg::DEFAULT_DEPTH,
    localparam int CNT_W = $clog2(GUIDE_DEPTH + 1),
    localparam int OUT_W = ((gsns_pkg::POS_W + 2 * CNT_W + gsns_pkg::STATUS_W + 7) / 8) * 8
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // op, position, new_position (lowest bit up)
    input  wire logic [gsns_pkg::IN_W-1:0]           s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // snap_position, standard_count, auto_count, status (lowest bit up)
    output logic      [OUT_W-1:0]                    m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_we,
    input  wire logic [gsns_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [gsns_pkg::REG_W-1:0]          cfg_wdata
);

    logic [gsns_pkg::POS_W-1:0] std_q  [GUIDE_DEPTH];
    logic [gsns_pkg::POS_W-1:0] auto_q [GUIDE_DEPTH];

    logic                          shift;
    logic [gsns_pkg::POS_W-1:0]    std_tail;
    logic [gsns_pkg::POS_W-1:0]    auto_tail;
    logic [gsns_pkg::POS_W-1:0]    snap_position;
    logic [CNT_W-1:0]              standard_count;
    logic [CNT_W-1:0]              auto_count;
    logic [gsns_pkg::STATUS_W-1:0] status;

    // Each cell takes its neighbour's entries; the last takes the edited head.
    for (genvar i = 0; i < GUIDE_DEPTH; i++)
    begin : g_chain
        if (i == GUIDE_DEPTH - 1)
        begin : g_tail
            gsns_cell u_cell
            (
                .clk     (clk),
                .shift   (shift),
                .std_in  (std_tail),
                .auto_in (auto_tail),
                .std_q   (std_q[i]),
                .auto_q  (auto_q[i])
            );
        end
        else
        begin : g_link
            gsns_cell u_cell
            (
                .clk     (clk),
                .shift   (shift),
                .std_in  (std_q[i+1]),
                .auto_in (auto_q[i+1]),
                .std_q   (std_q[i]),
                .auto_q  (auto_q[i])
            );
        end
    end

    gsns_ctrl #(
        .GUIDE_DEPTH (GUIDE_DEPTH)
    ) u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .in_op           (s_tdata[gsns_pkg::OP_W-1:0]),
        .in_position     (s_tdata[gsns_pkg::OP_W +: gsns_pkg::POS_W]),
        .in_new_position (s_tdata[gsns_pkg::OP_W + gsns_pkg::POS_W +: gsns_pkg::POS_W]),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .std_head        (std_q[0]),
        .std_next        (std_q[1]),
        .auto_head       (auto_q[0]),
        .shift           (shift),
        .std_tail        (std_tail),
        .auto_tail       (auto_tail),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .snap_position   (snap_position),
        .standard_count  (standard_count),
        .auto_count      (auto_count),
        .status          (status)
    );

    assign m_tdata = OUT_W'({status, auto_count, standard_count, snap_position});

endmodule

`default_nettype wire

// ----- rtl/gsns_cell.sv -----
// One link of the guide chain: holds one standard and one auto entry.
`default_nettype none

module gsns_cell
(
    input  wire logic                            clk,
    input  wire logic                            shift,
    input  wire logic [gsns_pkg::POS_W-1:0]      std_in,
    input  wire logic [gsns_pkg::POS_W-1:0]      auto_in,
    output logic      [gsns_pkg::POS_W-1:0]      std_q,
    output logic      [gsns_pkg::POS_W-1:0]      auto_q
);

    logic [gsns_pkg::POS_W-1:0] std_reg;
    logic [gsns_pkg::POS_W-1:0] auto_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            std_reg  <= std_in;
            auto_reg <= auto_in;
        end
    end

    assign std_q  = std_reg;
    assign auto_q = auto_reg;

endmodule

`default_nettype wire

// ----- rtl/gsns_ctrl.sv -----
// Sequencer: rotates the chain once per word, edits the lists and folds snap queries.
`default_nettype none

module gsns_ctrl #(
    parameter int GUIDE_DEPTH = gsns_pkg::DEFAULT_DEPTH,
    localparam int CNT_W = $clog2(GUIDE_DEPTH + 1)
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [gsns_pkg::OP_W-1:0]              in_op,
    input  wire logic [gsns_pkg::POS_W-1:0]             in_position,
    input  wire logic [gsns_pkg::POS_W-1:0]             in_new_position,
    input  wire logic                                   cfg_we,
    input  wire logic [gsns_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [gsns_pkg::REG_W-1:0]             cfg_wdata,
    input  wire logic [gsns_pkg::POS_W-1:0]             std_head,
    input  wire logic [gsns_pkg::POS_W-1:0]             std_next,
    input  wire logic [gsns_pkg::POS_W-1:0]             auto_head,
    output logic                                        shift,
    output logic      [gsns_pkg::POS_W-1:0]             std_tail,
    output logic      [gsns_pkg::POS_W-1:0]             auto_tail,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [gsns_pkg::POS_W-1:0]             snap_position,
    output logic      [CNT_W-1:0]                       standard_count,
    output logic      [CNT_W-1:0]                       auto_count,
    output logic      [gsns_pkg::STATUS_W-1:0]          status
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(GUIDE_DEPTH);
    localparam logic [CNT_W-1:0] LAST_K  = CNT_W'(GUIDE_DEPTH - 1);

    gsns_pkg::state_t state_reg, state_next;
    gsns_pkg::op_t    op_reg, op_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] std_used_reg, std_used_next;
    logic [CNT_W-1:0] auto_used_reg, auto_used_next;
    logic             found_reg, found_next;
    logic signed [gsns_pkg::POS_W-1:0] pos_reg, pos_next;
    logic signed [gsns_pkg::POS_W-1:0] npos_reg, npos_next;
    logic signed [gsns_pkg::POS_W-1:0] best_std_reg, best_std_next;
    logic signed [gsns_pkg::POS_W-1:0] best_auto_reg, best_auto_next;

    logic [gsns_pkg::REG_W-1:0] page_extent_reg;
    logic [gsns_pkg::REG_W-1:0] margin_near_reg;
    logic [gsns_pkg::REG_W-1:0] margin_far_reg;

    logic                                out_valid_reg, out_valid_next;
    logic [gsns_pkg::POS_W-1:0]          snap_out_reg, snap_out_next;
    logic [CNT_W-1:0]                    stdc_out_reg, stdc_out_next;
    logic [CNT_W-1:0]                    autoc_out_reg, autoc_out_next;
    gsns_pkg::status_t                   status_out_reg, status_out_next;

    logic                                after;
    logic                                std_live;
    logic                                auto_live;
    logic                                match;
    logic                                del_now;
    logic [CNT_W-1:0]                    k_inc;
    logic signed [gsns_pkg::POS_W-1:0]   far_line;
    logic                                load;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_extent_reg <= gsns_pkg::PAGE_EXTENT_RST;
            margin_near_reg <= gsns_pkg::MARGIN_NEAR_RST;
            margin_far_reg  <= gsns_pkg::MARGIN_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gsns_pkg::REG_PAGE_EXTENT: page_extent_reg <= cfg_wdata;
                gsns_pkg::REG_MARGIN_NEAR: margin_near_reg <= cfg_wdata;
                gsns_pkg::REG_MARGIN_FAR:  margin_far_reg  <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsns_pkg::S_IDLE;
            std_used_reg  <= '0;
            auto_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            std_used_reg  <= std_used_next;
            auto_used_reg <= auto_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        npos_reg       <= npos_next;
        best_std_reg   <= best_std_next;
        best_auto_reg  <= best_auto_next;
        snap_out_reg   <= snap_out_next;
        stdc_out_reg   <= stdc_out_next;
        autoc_out_reg  <= autoc_out_next;
        status_out_reg <= status_out_next;
    end

    assign after     = (op_reg == gsns_pkg::OP_AFTER);
    assign std_live  = (k_reg < std_used_reg);
    assign auto_live = (k_reg < auto_used_reg);
    assign match     = std_live && (std_head == pos_reg);
    // From the first occurrence onwards each entry is replaced by its successor.
    assign del_now   = ((op_reg == gsns_pkg::OP_DEL_STD) || (op_reg == gsns_pkg::OP_MOVE_STD))
                       && (found_reg || match);
    assign k_inc     = k_reg + CNT_W'(1);
    assign far_line  = $signed({1'b0, page_extent_reg}) - $signed({1'b0, margin_far_reg});

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        npos_next       = npos_reg;
        best_std_next   = best_std_reg;
        best_auto_next  = best_auto_reg;
        std_used_next   = std_used_reg;
        auto_used_next  = auto_used_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        snap_out_next   = snap_out_reg;
        stdc_out_next   = stdc_out_reg;
        autoc_out_next  = autoc_out_reg;
        status_out_next = status_out_reg;
        shift           = 1'b0;
        std_tail        = del_now ? std_next : std_head;
        auto_tail       = auto_head;
        load            = 1'b0;

        case (op_reg)
            gsns_pkg::OP_ADD_STD:
            begin
                if ((k_reg == std_used_reg) && !found_reg)
                begin
                    std_tail = pos_reg;
                end
            end
            gsns_pkg::OP_MOVE_STD:
            begin
                if ((del_now && (k_inc == std_used_reg)) ||
                    (!del_now && (k_reg == std_used_reg)))
                begin
                    std_tail = npos_reg;
                end
            end
            gsns_pkg::OP_ADD_AUTO:
            begin
                if (k_reg == auto_used_reg)
                begin
                    auto_tail = pos_reg;
                end
            end
            default: ;
        endcase

        case (state_reg)
            gsns_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = gsns_pkg::op_t'(in_op);
                    pos_next   = in_position;
                    npos_next  = in_new_position;
                    k_next     = '0;
                    found_next = 1'b0;
                    if (gsns_pkg::op_t'(in_op) == gsns_pkg::OP_AFTER)
                    begin
                        best_std_next = $signed({1'b0, page_extent_reg});
                    end
                    else
                    begin
                        best_std_next = '0;
                    end
                    best_auto_next = best_std_next;
                    state_next     = gsns_pkg::S_SCAN;
                end
            end
            gsns_pkg::S_SCAN:
            begin
                shift      = 1'b1;
                found_next = found_reg || match;
                if (std_live && gsns_pkg::snap_take(after, std_head, pos_reg, best_std_reg))
                begin
                    best_std_next = std_head;
                end
                if (auto_live && gsns_pkg::snap_take(after, auto_head, pos_reg, best_auto_reg))
                begin
                    best_auto_next = auto_head;
                end
                k_next = k_inc;
                if (k_reg == LAST_K)
                begin
                    state_next = gsns_pkg::S_FOLD_AUTO;
                end
            end
            gsns_pkg::S_FOLD_AUTO:
            begin
                if (gsns_pkg::snap_take(after, best_auto_reg, pos_reg, best_std_reg))
                begin
                    best_std_next = best_auto_reg;
                end
                state_next = gsns_pkg::S_FOLD_NEAR;
            end
            gsns_pkg::S_FOLD_NEAR:
            begin
                if (gsns_pkg::snap_take(after, $signed({1'b0, margin_near_reg}), pos_reg,
                                        best_std_reg))
                begin
                    best_std_next = $signed({1'b0, margin_near_reg});
                end
                state_next = gsns_pkg::S_FOLD_FAR;
            end
            gsns_pkg::S_FOLD_FAR:
            begin
                if (gsns_pkg::snap_take(after, far_line, pos_reg, best_std_reg))
                begin
                    best_std_next = far_line;
                end
                state_next = gsns_pkg::S_DONE;
            end
            gsns_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load            = 1'b1;
                    status_out_next = gsns_pkg::ST_OK;
                    snap_out_next   = '0;
                    case (op_reg)
                        gsns_pkg::OP_ADD_STD:
                        begin
                            if (found_reg)
                            begin
                                status_out_next = gsns_pkg::ST_DUP;
                            end
                            else if (std_used_reg == DEPTH_C)
                            begin
                                status_out_next = gsns_pkg::ST_FULL;
                            end
                            else
                            begin
                                std_used_next = std_used_reg + CNT_W'(1);
                            end
                        end
                        gsns_pkg::OP_DEL_STD:
                        begin
                            if (found_reg)
                            begin
                                std_used_next = std_used_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_out_next = gsns_pkg::ST_NOTFOUND;
                            end
                        end
                        gsns_pkg::OP_MOVE_STD:
                        begin
                            if (!found_reg)
                            begin
                                if (std_used_reg == DEPTH_C)
                                begin
                                    status_out_next = gsns_pkg::ST_FULL;
                                end
                                else
                                begin
                                    status_out_next = gsns_pkg::ST_NOTFOUND;
                                    std_used_next   = std_used_reg + CNT_W'(1);
                                end
                            end
                        end
                        gsns_pkg::OP_CLR_STD:
                        begin
                            std_used_next = '0;
                        end
                        gsns_pkg::OP_ADD_AUTO:
                        begin
                            if (auto_used_reg == DEPTH_C)
                            begin
                                status_out_next = gsns_pkg::ST_FULL;
                            end
                            else
                            begin
                                auto_used_next = auto_used_reg + CNT_W'(1);
                            end
                        end
                        gsns_pkg::OP_CLR_AUTO:
                        begin
                            auto_used_next = '0;
                        end
                        default:
                        begin
                            snap_out_next = best_std_reg;
                        end
                    endcase
                    stdc_out_next  = std_used_next;
                    autoc_out_next = auto_used_next;
                    out_valid_next = 1'b1;
                    state_next     = gsns_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gsns_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready       = (state_reg == gsns_pkg::S_IDLE);
    assign m_tvalid       = out_valid_reg;
    assign snap_position  = snap_out_reg;
    assign standard_count = stdc_out_reg;
    assign auto_count     = autoc_out_reg;
    assign status         = status_out_reg;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (std_used_reg <= DEPTH_C) && (auto_used_reg <= DEPTH_C))
        else $error("guide count beyond depth");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == gsns_pkg::S_SCAN) && (k_reg == '0))
        else $error("accepted word did not start a scan");

    a_used_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gsns_pkg::S_DONE) |=> $stable(std_used_reg) && $stable(auto_used_reg))
        else $error("list count changed outside completion");

    a_dup_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (status_out_next == gsns_pkg::ST_DUP))
        |=> (std_used_reg == $past(std_used_reg)))
        else $error("duplicate add changed the standard count");
`endif

endmodule

`default_nettype wire

// ----- bench/guide_store_nearest_snap_tb.sv -----
// Self-checking testbench for the guide store with nearest-line snapping.
`timescale 1ns / 100ps

module guide_store_nearest_snap_tb;

    localparam int DEPTH        = gsns_pkg::DEFAULT_DEPTH;
    localparam int POS_W        = gsns_pkg::POS_W;
    localparam int REG_W        = gsns_pkg::REG_W;
    localparam int OP_W         = gsns_pkg::OP_W;
    localparam int STATUS_W     = gsns_pkg::STATUS_W;
    localparam int CFG_ADDR_W   = gsns_pkg::CFG_ADDR_W;
    localparam int IN_W         = gsns_pkg::IN_W;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int OUT_W        = ((POS_W + 2 * CNT_W + STATUS_W + 7) / 8) * 8;
    localparam int POOL_N       = 48;
    localparam int DIR_N        = 23;
    localparam int EPISODES     = 8;
    localparam int EPISODE_LEN  = 120;
    localparam int STALL_CYCLES = 400;
    localparam int REPORT_MAX   = 10;

    // Index past the last register; writes there must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] snap;
        logic [CNT_W-1:0]        std_n;
        logic [CNT_W-1:0]        auto_n;
        gsns_pkg::status_t       st;
    } guide_result_t;

    typedef struct packed {
        gsns_pkg::op_t           op;
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] npos;
        logic                    typed;
        guide_result_t           res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;

    // Model of the store, kept in step with every accepted word.
    logic signed [POS_W-1:0] std_list [DEPTH];
    logic signed [POS_W-1:0] auto_list [DEPTH];
    int                      std_n = 0;
    int                      auto_n = 0;
    logic [REG_W-1:0]        page_extent = gsns_pkg::PAGE_EXTENT_RST;
    logic [REG_W-1:0]        margin_near = gsns_pkg::MARGIN_NEAR_RST;
    logic [REG_W-1:0]        margin_far  = gsns_pkg::MARGIN_FAR_RST;

    guide_result_t           due_results [$];
    guide_result_t           got_word;
    guide_result_t           want_word;
    int                      mismatches = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    logic                    stall_req = 1'b0;
    logic signed [POS_W-1:0] pos_pool [POOL_N];

    stim_row_t dir_rows [DIR_N] = '{
        '{gsns_pkg::OP_BEFORE,   32'sh7fffffff, 32'sd0,        1'b1,
          '{32'sd52559872, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_AFTER,    32'sh80000000, 32'sd0,        1'b1,
          '{32'sd2621440, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_DEL_STD,  32'sd5,        32'sd0,        1'b1,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_NOTFOUND}},
        '{gsns_pkg::OP_MOVE_STD, 32'sd7,        32'sh80000000, 1'b1,
          '{32'sd0, 7'd1, 7'd0, gsns_pkg::ST_NOTFOUND}},
        '{gsns_pkg::OP_ADD_STD,  32'sh80000000, 32'shffffffff, 1'b1,
          '{32'sd0, 7'd1, 7'd0, gsns_pkg::ST_DUP}},
        '{gsns_pkg::OP_ADD_STD,  32'sh7fffffff, 32'sd0,        1'b1,
          '{32'sd0, 7'd2, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_ADD_STD,  32'sd0,        32'sh7fffffff, 1'b1,
          '{32'sd0, 7'd3, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_ADD_STD,  32'shffffffff, 32'sd0,        1'b1,
          '{32'sd0, 7'd4, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_ADD_AUTO, 32'sh7fffffff, 32'sd0,        1'b1,
          '{32'sd0, 7'd4, 7'd1, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_ADD_AUTO, 32'sh7fffffff, 32'sd0,        1'b1,
          '{32'sd0, 7'd4, 7'd2, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_ADD_AUTO, 32'sd1000,     32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_BEFORE,   32'sd0,        32'sd0,        1'b1,
          '{32'sd0, 7'd4, 7'd3, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_AFTER,    32'sh7ffffffe, 32'sd0,        1'b1,
          '{32'sd55181312, 7'd4, 7'd3, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_AFTER,    32'sd0,        32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_BEFORE,   32'sd3000000,  32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_MOVE_STD, 32'sd0,        32'sd12345,    1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_DEL_STD,  32'sh7fffffff, 32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_DEL_STD,  32'sh7fffffff, 32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_AFTER,    32'sd12345,    32'sd0,        1'b0,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_CLR_AUTO, 32'sh5a5a5a5a, 32'sha5a5a5a5, 1'b1,
          '{32'sd0, 7'd3, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_CLR_STD,  32'sha5a5a5a5, 32'sh5a5a5a5a, 1'b1,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_BEFORE,   32'sh80000000, 32'sd0,        1'b1,
          '{32'sd0, 7'd0, 7'd0, gsns_pkg::ST_OK}},
        '{gsns_pkg::OP_AFTER,    32'sd55181312, 32'sd0,        1'b1,
          '{32'sd55181312, 7'd0, 7'd0, gsns_pkg::ST_OK}}
    };

    guide_store_nearest_snap #(.GUIDE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int find_std(input logic signed [POS_W-1:0] v);
        int at;
        at = -1;
        for (int i = std_n - 1; i >= 0; i--)
        begin
            if (std_list[i] == v)
            begin
                at = i;
            end
        end
        return at;
    endfunction

    function automatic void drop_std(input int at);
        for (int i = at; i + 1 < std_n; i++)
        begin
            std_list[i] = std_list[i + 1];
        end
        std_n--;
    endfunction

    // Closest line strictly beyond y in the chosen direction; the page edges bound it.
    function automatic logic signed [POS_W-1:0] nearest_line(input longint y, input logic after);
        longint best;
        longint g;
        best = after ? longint'(page_extent) : 64'sd0;
        for (int i = 0; i < std_n + auto_n + 2; i++)
        begin
            if (i < std_n)
                g = longint'(std_list[i]);
            else if (i < std_n + auto_n)
                g = longint'(auto_list[i - std_n]);
            else if (i == std_n + auto_n)
                g = longint'(margin_near);
            else
                g = longint'(page_extent) - longint'(margin_far);
            if (after ? (g > y && g < best) : (g < y && g > best))
                best = g;
        end
        return best[POS_W-1:0];
    endfunction

    function automatic guide_result_t apply_guide_op(input gsns_pkg::op_t op,
                                                     input logic signed [POS_W-1:0] pos,
                                                     input logic signed [POS_W-1:0] npos);
        guide_result_t r;
        int at;
        r.snap = '0;
        r.st = gsns_pkg::ST_OK;
        case (op)
            gsns_pkg::OP_ADD_STD:
            begin
                if (find_std(pos) >= 0)
                    r.st = gsns_pkg::ST_DUP;
                else if (std_n >= DEPTH)
                    r.st = gsns_pkg::ST_FULL;
                else
                begin
                    std_list[std_n] = pos;
                    std_n++;
                end
            end
            gsns_pkg::OP_DEL_STD:
            begin
                at = find_std(pos);
                if (at < 0)
                    r.st = gsns_pkg::ST_NOTFOUND;
                else
                    drop_std(at);
            end
            gsns_pkg::OP_MOVE_STD:
            begin
                at = find_std(pos);
                if (at < 0)
                    r.st = gsns_pkg::ST_NOTFOUND;
                else
                    drop_std(at);
                if (std_n >= DEPTH)
                    r.st = gsns_pkg::ST_FULL;
                else
                begin
                    std_list[std_n] = npos;
                    std_n++;
                end
            end
            gsns_pkg::OP_CLR_STD:
                std_n = 0;
            gsns_pkg::OP_ADD_AUTO:
            begin
                if (auto_n >= DEPTH)
                    r.st = gsns_pkg::ST_FULL;
                else
                begin
                    auto_list[auto_n] = pos;
                    auto_n++;
                end
            end
            gsns_pkg::OP_CLR_AUTO:
                auto_n = 0;
            gsns_pkg::OP_BEFORE:
                r.snap = nearest_line(longint'(pos), 1'b0);
            default:
                r.snap = nearest_line(longint'(pos), 1'b1);
        endcase
        r.std_n = std_n[CNT_W-1:0];
        r.auto_n = auto_n[CNT_W-1:0];
        return r;
    endfunction

    // Mostly values near the page and the snap lines, with extremes and noise mixed in.
    function automatic logic signed [POS_W-1:0] pick_position();
        logic signed [POS_W-1:0] v;
        int off;
        off = int'($urandom_range(2)) - 1;
        case ($urandom_range(9))
            0, 1, 2: v = pos_pool[$urandom_range(POOL_N - 1)];
            3:       v = pos_pool[$urandom_range(POOL_N - 1)] + off;
            4, 5:    v = $urandom;
            6:
            begin
                case ($urandom_range(3))
                    0:       v = 32'sh80000000;
                    1:       v = 32'sh7fffffff;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            7:       v = int'(margin_near) + off;
            8:       v = ($urandom_range(1) ? int'(page_extent)
                                            : int'(page_extent) - int'(margin_far)) + off;
            default: v = $urandom_range(page_extent);
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_held(input int pct);
        logic signed [POS_W-1:0] v;
        if (std_n > 0 && $urandom_range(99) < pct)
            v = std_list[$urandom_range(std_n - 1)];
        else
            v = pick_position();
        return v;
    endfunction

    // Filling episodes grow both lists towards full; the others churn them.
    function automatic gsns_pkg::op_t pick_op(input logic filling);
        int r;
        gsns_pkg::op_t op;
        r = $urandom_range(99);
        if (filling)
        begin
            if (r < 40)      op = gsns_pkg::OP_ADD_STD;
            else if (r < 70) op = gsns_pkg::OP_ADD_AUTO;
            else if (r < 78) op = gsns_pkg::OP_MOVE_STD;
            else if (r < 84) op = gsns_pkg::OP_DEL_STD;
            else if (r < 92) op = gsns_pkg::OP_BEFORE;
            else             op = gsns_pkg::OP_AFTER;
        end
        else
        begin
            if (r < 18)      op = gsns_pkg::OP_ADD_STD;
            else if (r < 32) op = gsns_pkg::OP_DEL_STD;
            else if (r < 44) op = gsns_pkg::OP_MOVE_STD;
            else if (r < 47) op = gsns_pkg::OP_CLR_STD;
            else if (r < 57) op = gsns_pkg::OP_ADD_AUTO;
            else if (r < 60) op = gsns_pkg::OP_CLR_AUTO;
            else if (r < 80) op = gsns_pkg::OP_BEFORE;
            else             op = gsns_pkg::OP_AFTER;
        end
        return op;
    endfunction

    task automatic offer_word(input gsns_pkg::op_t op, input logic signed [POS_W-1:0] pos,
                              input logic signed [POS_W-1:0] npos, input logic typed,
                              input guide_result_t typed_res);
        guide_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata = IN_W'({$urandom, $urandom, $urandom});
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(IN_W - OP_W - 2 * POS_W){1'b0}}, npos, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_guide_op(op, pos, npos);
        due_results.push_back(typed ? typed_res : predicted);
    endtask

    // Waits until every result is back and the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            gsns_pkg::REG_PAGE_EXTENT: page_extent = val;
            gsns_pkg::REG_MARGIN_NEAR: margin_near = val;
            gsns_pkg::REG_MARGIN_FAR:  margin_far = val;
            default:                   ;
        endcase
    endtask

    task automatic set_page(input logic [REG_W-1:0] extent, input logic [REG_W-1:0] near,
                            input logic [REG_W-1:0] far);
        write_reg(gsns_pkg::REG_PAGE_EXTENT, extent);
        write_reg(gsns_pkg::REG_MARGIN_NEAR, near);
        write_reg(gsns_pkg::REG_MARGIN_FAR, far);
    endtask

    // Receiver side; a requested hold-off is counted out here while the sender keeps going.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                m_tready = 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.snap   = m_tdata[POS_W-1:0];
            got_word.std_n  = m_tdata[POS_W+CNT_W-1:POS_W];
            got_word.auto_n = m_tdata[POS_W+2*CNT_W-1:POS_W+CNT_W];
            got_word.st     =
                gsns_pkg::status_t'(m_tdata[POS_W+2*CNT_W+STATUS_W-1:POS_W+2*CNT_W]);
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected word: snap %0d std %0d auto %0d status %0d",
                             $realtime, got_word.snap, got_word.std_n, got_word.auto_n,
                             got_word.st);
            end
            else
            begin
                want_word = due_results.pop_front();
                if (got_word.snap !== want_word.snap || got_word.std_n !== want_word.std_n ||
                    got_word.auto_n !== want_word.auto_n || got_word.st !== want_word.st)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 $realtime, want_word.snap, want_word.std_n,
                                 want_word.auto_n, want_word.st, got_word.snap,
                                 got_word.std_n, got_word.auto_n, got_word.st);
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        gsns_pkg::op_t op;
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] np;
        guide_result_t unused_res;

        unused_res = '0;
        for (int i = 0; i < POOL_N; i++)
            pos_pool[i] = (i % 3 == 0) ? $urandom : $urandom_range(60000000);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 68;
        for (int k = 0; k < DIR_N; k++)
        begin
            row = dir_rows[k];
            offer_word(row.op, row.pos, row.npos, row.typed, row.res);
        end

        for (int ep = 0; ep < EPISODES; ep++)
        begin
            if (ep > 0)
            begin
                settle();
                case (ep)
                    1:
                    begin
                        set_page(31'h7fffffff, 31'd0, 31'd0);
                        write_reg(REG_UNUSED, REG_W'($urandom));
                    end
                    // Far margin beyond the page puts the far line below zero.
                    2: set_page(31'd1000000, 31'd500000, 31'h7fffffff);
                    3, 6: set_page(REG_W'($urandom), REG_W'($urandom_range(4000000)),
                                   REG_W'($urandom_range(70000000)));
                    4: set_page(31'd0, 31'd0, 31'd0);
                    5: set_page(31'd60000000, 31'h7fffffff, 31'h7fffffff);
                    default: set_page(gsns_pkg::PAGE_EXTENT_RST, gsns_pkg::MARGIN_NEAR_RST,
                                      gsns_pkg::MARGIN_FAR_RST);
                endcase
            end
            if (ep == 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 10;
            end
            if (ep == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stall_req = 1'b1;
            end
            for (int k = 0; k < EPISODE_LEN; k++)
            begin
                op = pick_op(ep % 2 == 0);
                np = $urandom;
                case (op)
                    gsns_pkg::OP_ADD_STD:   p = pick_held(30);
                    gsns_pkg::OP_DEL_STD, gsns_pkg::OP_MOVE_STD:
                    begin
                        p = pick_held(60);
                        if (op == gsns_pkg::OP_MOVE_STD && $urandom_range(1))
                            np = pick_position();
                    end
                    gsns_pkg::OP_CLR_STD, gsns_pkg::OP_CLR_AUTO: p = $urandom;
                    default:                p = pick_position();
                endcase
                offer_word(op, p, np, 1'b0, unused_res);
            end
        end

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
